/* design/vkd_pkg.sv */
// shared constants and helper functions for the vertex key dedup table
`default_nettype none
package vkd_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int KEY_SLOTS_DEF     = 4;
    localparam int INDEX_WIDTH_DEF   = 16;

    localparam int IN_SLOTS  = 4;
    localparam int FIELD_W   = 16;
    localparam int VIDX_W    = 10;
    localparam int SLOTS_W   = 3;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic REG_SLOTS_IN_USE = 1'b0;

    function automatic int avail_slots(input int key_slots);
        return (key_slots < IN_SLOTS) ? key_slots : IN_SLOTS;
    endfunction

    function automatic int slot_width(input int index_width);
        return (index_width < FIELD_W) ? index_width : FIELD_W;
    endfunction

endpackage
`default_nettype wire

/* design/vkd_if.sv */
// corner input and vertex result channel interfaces
`default_nettype none
interface vkd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        clear_first;
    logic [vkd_pkg::FIELD_W-1:0] idx0;
    logic [vkd_pkg::FIELD_W-1:0] idx1;
    logic [vkd_pkg::FIELD_W-1:0] idx2;
    logic [vkd_pkg::FIELD_W-1:0] idx3;

    modport source (output valid, clear_first, idx0, idx1, idx2, idx3, input ready);
    modport sink (input valid, clear_first, idx0, idx1, idx2, idx3, output ready);
endinterface

interface vkd_out_if;
    logic                       valid;
    logic                       ready;
    logic [vkd_pkg::VIDX_W-1:0] vertex_index;
    logic                       is_new;
    logic                       table_full;

    modport source (output valid, vertex_index, is_new, table_full, input ready);
    modport sink (input valid, vertex_index, is_new, table_full, output ready);
endinterface
`default_nettype wire

/* design/vkd_key_mem.sv */
// key store memory, one write and one registered read port
`default_nettype none
module vkd_key_mem #(
    parameter int DEPTH = vkd_pkg::TABLE_ENTRIES_DEF,
    parameter int WIDTH = vkd_pkg::KEY_SLOTS_DEF * vkd_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* design/vkd_key_cmp.sv */
// masked slot compare of a stored key against the probe key
`default_nettype none
module vkd_key_cmp #(
    parameter int SLOTS  = vkd_pkg::KEY_SLOTS_DEF,
    parameter int SLOT_W = vkd_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic [SLOTS*SLOT_W-1:0] i_entry,
    input  wire logic [SLOTS*SLOT_W-1:0] i_key,
    input  wire logic [SLOTS-1:0]        i_mask,
    output logic                         o_match
);

    logic [SLOTS-1:0] w_diff;

    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            w_diff[s] = i_mask[s] && (i_entry[s*SLOT_W +: SLOT_W] != i_key[s*SLOT_W +: SLOT_W]);
        end
    end

    assign o_match = (w_diff == '0);

endmodule
`default_nettype wire

/* design/vertex_key_dedup_table.sv */
// vertex_key_dedup_table: top level, scan sequencer, result register and config port
//
// one corner beat in on i_in (clear_first and four indices), one result beat
// out on o_out (vertex_index, is_new, table_full). the key store is scanned
// in order from entry 0, one memory read per cycle through a single compare
// unit; the first stored key that matches over the active slots wins. on a
// miss the key is written at the next free entry, or table_full is flagged
// when all TABLE_ENTRIES entries are taken.
// one corner is in work at a time: i_in.ready is high only while the
// sequencer is idle, and a corner is accepted even while the previous
// result still waits on o_out.
// a stalled o_out holds its beat; a finished scan then waits for the slot.
// reset empties the table (vertex count 0) and sets slots_in_use to 1; the
// key store itself needs no clearing. slots_in_use sits at address 0 of the
// apb port. slots_in_use must be written by the user only while the block
// is idle; the block itself does not enforce this.
`default_nettype none
module vertex_key_dedup_table #(
    parameter int TABLE_ENTRIES = vkd_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_SLOTS     = vkd_pkg::KEY_SLOTS_DEF,
    parameter int INDEX_WIDTH   = vkd_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    vkd_in_if.sink                             i_in,
    vkd_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vkd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [vkd_pkg::PDATA_W-1:0]   pwdata,
    output logic                               pready,
    output logic      [vkd_pkg::PDATA_W-1:0]   prdata
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int CW    = AW + 1;
    localparam int AVAIL = vkd_pkg::avail_slots(KEY_SLOTS);
    localparam int SW    = vkd_pkg::slot_width(INDEX_WIDTH);
    localparam int KW    = AVAIL * SW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RES  = 2'd2;

    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    logic [1:0]                    r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_addr, n_addr;
    logic                          r_rd_vld, n_rd_vld;
    logic [AW-1:0]                 r_rd_addr, n_rd_addr;
    logic [KW-1:0]                 r_key, n_key;
    logic [AVAIL-1:0]              r_mask, n_mask;
    logic [AW-1:0]                 r_res_idx, n_res_idx;
    logic                          r_res_new, n_res_new;
    logic                          r_res_full, n_res_full;
    logic                          r_ovld, n_ovld;
    logic [vkd_pkg::VIDX_W-1:0]    r_o_vidx, n_o_vidx;
    logic                          r_o_new, n_o_new;
    logic                          r_o_full, n_o_full;
    logic [vkd_pkg::SLOTS_W-1:0]   r_slots;

    logic [vkd_pkg::FIELD_W-1:0]   w_idx [vkd_pkg::IN_SLOTS];
    logic [KW-1:0]                 w_key;
    logic [vkd_pkg::SLOTS_W-1:0]   w_act;
    logic [AVAIL-1:0]              w_mask;
    logic                          w_accept;
    logic                          w_we;
    logic                          w_re;
    logic [KW-1:0]                 w_rdata;
    logic                          w_match;
    logic                          w_cfg_wr;

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= vkd_pkg::SLOTS_W'(1);
        end else if (w_cfg_wr && (paddr[2] == vkd_pkg::REG_SLOTS_IN_USE)) begin
            r_slots <= pwdata[vkd_pkg::SLOTS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == vkd_pkg::REG_SLOTS_IN_USE) begin
            prdata = vkd_pkg::PDATA_W'(r_slots);
        end
    end

    // probe key and active slot mask
    assign w_idx[0] = i_in.idx0;
    assign w_idx[1] = i_in.idx1;
    assign w_idx[2] = i_in.idx2;
    assign w_idx[3] = i_in.idx3;

    always_comb begin
        for (int s = 0; s < AVAIL; s++) begin
            w_key[s*SW +: SW] = w_idx[s][SW-1:0];
        end
    end

    always_comb begin
        if (r_slots == '0) begin
            w_act = vkd_pkg::SLOTS_W'(1);
        end else if (r_slots > vkd_pkg::SLOTS_W'(AVAIL)) begin
            w_act = vkd_pkg::SLOTS_W'(AVAIL);
        end else begin
            w_act = r_slots;
        end
        for (int s = 0; s < AVAIL; s++) begin
            w_mask[s] = (vkd_pkg::SLOTS_W'(s) < w_act);
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    vkd_key_mem #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (KW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_key),
        .i_re    (w_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    vkd_key_cmp #(
        .SLOTS  (AVAIL),
        .SLOT_W (SW)
    ) u_cmp (
        .i_entry (w_rdata),
        .i_key   (r_key),
        .i_mask  (r_mask),
        .o_match (w_match)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_addr     = r_addr;
        n_rd_vld   = r_rd_vld;
        n_rd_addr  = r_rd_addr;
        n_key      = r_key;
        n_mask     = r_mask;
        n_res_idx  = r_res_idx;
        n_res_new  = r_res_new;
        n_res_full = r_res_full;
        n_ovld     = r_ovld && !o_out.ready;
        n_o_vidx   = r_o_vidx;
        n_o_new    = r_o_new;
        n_o_full   = r_o_full;
        w_we       = 1'b0;
        w_re       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_key    = w_key;
                    n_mask   = w_mask;
                    n_addr   = '0;
                    n_rd_vld = 1'b0;
                    if (i_in.clear_first) begin
                        n_count = '0;
                    end
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_rd_vld = 1'b0;
                if (r_rd_vld && w_match) begin
                    n_res_idx  = r_rd_addr;
                    n_res_new  = 1'b0;
                    n_res_full = 1'b0;
                    n_state    = ST_RES;
                end else if (r_addr == r_count) begin
                    if (r_count == FULL_COUNT) begin
                        n_res_idx  = '0;
                        n_res_new  = 1'b0;
                        n_res_full = 1'b1;
                    end else begin
                        w_we       = 1'b1;
                        n_res_idx  = r_count[AW-1:0];
                        n_res_new  = 1'b1;
                        n_res_full = 1'b0;
                        n_count    = r_count + CW'(1);
                    end
                    n_state = ST_RES;
                end else begin
                    w_re      = 1'b1;
                    n_rd_addr = r_addr[AW-1:0];
                    n_addr    = r_addr + CW'(1);
                    n_rd_vld  = 1'b1;
                end
            end
            ST_RES: begin
                if (!r_ovld || o_out.ready) begin
                    n_ovld   = 1'b1;
                    n_o_vidx = vkd_pkg::VIDX_W'(r_res_idx);
                    n_o_new  = r_res_new;
                    n_o_full = r_res_full;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            r_ovld   <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_rd_addr  <= n_rd_addr;
        r_key      <= n_key;
        r_mask     <= n_mask;
        r_res_idx  <= n_res_idx;
        r_res_new  <= n_res_new;
        r_res_full <= n_res_full;
        r_o_vidx   <= n_o_vidx;
        r_o_new    <= n_o_new;
        r_o_full   <= n_o_full;
    end

    assign o_out.valid        = r_ovld;
    assign o_out.vertex_index = r_o_vidx;
    assign o_out.is_new       = r_o_new;
    assign o_out.table_full   = r_o_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("vertex count beyond table size");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_count < FULL_COUNT))
        else $error("key write into a full table");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_addr <= r_count))
        else $error("scan address past vertex count");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN))
        else $error("accepted beat did not start a scan");

    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_o_full) |-> (!r_o_new && (r_o_vidx == '0)))
        else $error("full result with new flag or nonzero index");

endmodule
`default_nettype wire
